// File: design/scf_pkg.sv
// Shared types and constants of the servo command framer.
// Used by the packet builder and the top level.
// No dependencies.
`default_nettype none

package scf_pkg;

    // Packet geometry: two header bytes, id, length and instruction come
    // first, then up to five parameters, then the checksum.
    localparam int PKT_BYTES  = 11;
    localparam int HEAD_BYTES = 5;
    localparam int PRM_MAX    = 5;

    // Command codes carried in the mode field.
    localparam logic [2:0] MODE_GOAL       = 3'd0;
    localparam logic [2:0] MODE_SPEED      = 3'd1;
    localparam logic [2:0] MODE_WHEEL      = 3'd2;
    localparam logic [2:0] MODE_LED        = 3'd3;
    localparam logic [2:0] MODE_WHEEL_LIM  = 3'd4;
    localparam logic [2:0] MODE_JOINT_LIM  = 3'd5;
    localparam logic [2:0] MODE_READ_POS   = 3'd6;
    localparam logic [2:0] MODE_PING       = 3'd7;

    // Fixed packet bytes.
    localparam logic [7:0] PKT_HEADER    = 8'hFF;
    localparam logic [7:0] SPEED_ADDR    = 8'h20;
    localparam logic [7:0] LIMIT_ADDR    = 8'h06;
    localparam logic [7:0] POS_READ_ADDR = 8'h24;
    localparam logic [7:0] READ_COUNT    = 8'h02;
    localparam logic [7:0] READ_INSTR    = 8'h02;
    localparam logic [7:0] PING_INSTR    = 8'h01;
    localparam logic [7:0] JOINT_LIM_LO  = 8'hFF;
    localparam logic [7:0] JOINT_LIM_HI  = 8'h03;

    // Value word limits: ten magnitude bits and a direction bit.
    localparam logic [10:0] VALUE_MAX = 11'd1023;
    localparam logic [10:0] DIR_BIT   = 11'h400;

    // Register map, indexed by paddr[3:2].
    localparam logic [1:0] REG_WRITE_OPCODE = 2'd0;
    localparam logic [1:0] REG_GOAL_ADDRESS = 2'd1;
    localparam logic [1:0] REG_LED_ADDRESS  = 2'd2;

    localparam logic [7:0] RST_WRITE_OPCODE = 8'd3;
    localparam logic [7:0] RST_GOAL_ADDRESS = 8'd30;
    localparam logic [7:0] RST_LED_ADDRESS  = 8'd25;

    typedef struct packed {
        logic [7:0] write_opcode;
        logic [7:0] goal_address;
        logic [7:0] led_address;
    } scf_cfg_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  servo_id;
        logic [15:0] value;
    } scf_cmd_t;

    typedef struct packed {
        logic [PKT_BYTES-1:0][7:0] bytes;
        logic [3:0]                last_idx;
    } scf_pkt_t;

endpackage

`default_nettype wire

// File: design/scf_if.sv
// Valid/ready channel interfaces of the servo command framer: the command
// channel and the packet byte channel. No dependencies.
`default_nettype none

interface scf_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [7:0]  servo_id;
    logic [15:0] value;

    modport source (output valid, output mode, output servo_id, output value, input ready);
    modport sink   (input valid, input mode, input servo_id, input value, output ready);
endinterface

interface scf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last;

    modport source (output valid, output tx_byte, output last, input ready);
    modport sink   (input valid, input tx_byte, input last, output ready);
endinterface

`default_nettype wire

// File: design/scf_packet_builder.sv
// Packet builder: turns one command and the register values into the whole
// instruction packet with its length and checksum. Depends on scf_pkg.
`default_nettype none

module scf_packet_builder (
    input  wire scf_pkg::scf_cmd_t cmd,
    input  wire scf_pkg::scf_cfg_t cfg,
    output scf_pkg::scf_pkt_t      pkt
);

    logic [15:0]                    neg_value;
    logic [10:0]                    wheel_word;
    logic [10:0]                    clamp_word;
    logic [10:0]                    word;
    logic [scf_pkg::PRM_MAX-1:0][7:0] prm;
    logic [2:0]                     np;
    logic [7:0]                     instr;
    logic [7:0]                     len_byte;
    logic [7:0]                     sum;
    logic [3:0]                     chk_idx;

    // Unsigned clamp to the ten-bit range.
    assign clamp_word = (cmd.value[15:10] != 6'd0) ? scf_pkg::VALUE_MAX : cmd.value[10:0];

    // Signed wheel speed: negative values go out as magnitude with the
    // direction bit set.
    assign neg_value = 16'(~cmd.value + 16'd1);

    always_comb
    begin
        if (cmd.value[15])
        begin
            if (neg_value[15:10] != 6'd0)
                wheel_word = scf_pkg::VALUE_MAX | scf_pkg::DIR_BIT;
            else
                wheel_word = neg_value[10:0] | scf_pkg::DIR_BIT;
        end
        else
        begin
            wheel_word = clamp_word;
        end
    end

    always_comb
    begin
        prm   = '0;
        np    = 3'd0;
        instr = cfg.write_opcode;
        word  = (cmd.mode == scf_pkg::MODE_WHEEL) ? wheel_word : clamp_word;
        unique case (cmd.mode)
            scf_pkg::MODE_GOAL, scf_pkg::MODE_SPEED, scf_pkg::MODE_WHEEL:
            begin
                prm[0] = (cmd.mode == scf_pkg::MODE_GOAL) ? cfg.goal_address
                                                          : scf_pkg::SPEED_ADDR;
                prm[1] = word[7:0];
                prm[2] = {5'd0, word[10:8]};
                np     = 3'd3;
            end
            scf_pkg::MODE_LED:
            begin
                prm[0] = cfg.led_address;
                prm[1] = (cmd.value != 16'd0) ? 8'd1 : 8'd0;
                np     = 3'd2;
            end
            scf_pkg::MODE_WHEEL_LIM, scf_pkg::MODE_JOINT_LIM:
            begin
                prm[0] = scf_pkg::LIMIT_ADDR;
                if (cmd.mode == scf_pkg::MODE_JOINT_LIM)
                begin
                    prm[3] = scf_pkg::JOINT_LIM_LO;
                    prm[4] = scf_pkg::JOINT_LIM_HI;
                end
                np = 3'd5;
            end
            scf_pkg::MODE_READ_POS:
            begin
                instr  = scf_pkg::READ_INSTR;
                prm[0] = scf_pkg::POS_READ_ADDR;
                prm[1] = scf_pkg::READ_COUNT;
                np     = 3'd2;
            end
            default:
            begin
                instr = scf_pkg::PING_INSTR;
                np    = 3'd0;
            end
        endcase
    end

    assign len_byte = {5'd0, np} + 8'd2;
    // Unused parameter slots are zero, so all five can be summed.
    assign sum      = cmd.servo_id + len_byte + instr
                    + prm[0] + prm[1] + prm[2] + prm[3] + prm[4];
    assign chk_idx  = 4'(scf_pkg::HEAD_BYTES) + {1'b0, np};

    always_comb
    begin
        pkt.bytes    = '0;
        pkt.bytes[0] = scf_pkg::PKT_HEADER;
        pkt.bytes[1] = scf_pkg::PKT_HEADER;
        pkt.bytes[2] = cmd.servo_id;
        pkt.bytes[3] = len_byte;
        pkt.bytes[4] = instr;
        for (int k = 0; k < scf_pkg::PRM_MAX; k++)
        begin
            pkt.bytes[scf_pkg::HEAD_BYTES + k] = prm[k];
        end
        pkt.bytes[chk_idx] = ~sum;
        pkt.last_idx       = chk_idx;
    end

endmodule

`default_nettype wire

// File: design/servo_command_framer.sv
// Servo command framer top level: command register, packet register with a
// byte serialiser, and the APB register file.
// Depends on scf_pkg, scf_if.sv and scf_packet_builder.
//
// Usage. A command (mode, servo_id, value) arrives as a valid/ready
// transaction on the cmd channel. The block answers with the whole
// instruction packet on the pkt channel, one byte per transaction, with
// last set on the closing checksum byte. Packets are 6 to 11 bytes long
// depending on the mode.
// A command goes from the command register into the packet register once
// the packet register is free, and its first byte is offered from there.
// Throughput: one packet byte per cycle while the receiver holds ready;
// every packet goes out over the single byte output lane.
// The command register takes the next command while the current packet is
// still being sent, and its packet is loaded in the cycle that the last
// byte of the previous packet is taken, so packets follow without a gap.
// When the receiver stalls, the current byte holds and the command register
// fills and then drops ready until the packet completes.
// Reset clears both valid flags and returns the three registers
// (write_opcode 3, goal_address 30, led_address 25) to their defaults.
// Registers are written over APB at byte addresses 0, 4 and 8, paddr[1:0]
// unused, 12-15 ignored. Write them only while the block is idle.
`default_nettype none

module servo_command_framer (
    input  wire         clk,
    input  wire         rst_n,
    scf_cmd_if.sink     cmd,
    scf_byte_if.source  pkt,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    scf_pkg::scf_cfg_t cfg_reg;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.write_opcode <= scf_pkg::RST_WRITE_OPCODE;
            cfg_reg.goal_address <= scf_pkg::RST_GOAL_ADDRESS;
            cfg_reg.led_address  <= scf_pkg::RST_LED_ADDRESS;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                scf_pkg::REG_WRITE_OPCODE: cfg_reg.write_opcode <= pwdata[7:0];
                scf_pkg::REG_GOAL_ADDRESS: cfg_reg.goal_address <= pwdata[7:0];
                scf_pkg::REG_LED_ADDRESS:  cfg_reg.led_address  <= pwdata[7:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            scf_pkg::REG_WRITE_OPCODE: prdata = {24'd0, cfg_reg.write_opcode};
            scf_pkg::REG_GOAL_ADDRESS: prdata = {24'd0, cfg_reg.goal_address};
            scf_pkg::REG_LED_ADDRESS:  prdata = {24'd0, cfg_reg.led_address};
            default:                   prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Command register
    // ------------------------------------------------------------------
    logic              cmd_valid_reg;
    logic              cmd_valid_next;
    scf_pkg::scf_cmd_t cmd_reg;
    logic              cmd_accept;
    logic              pkt_load;

    // The register frees up in the same cycle that its command moves on
    // into the packet register.
    assign cmd.ready  = !cmd_valid_reg || pkt_load;
    assign cmd_accept = cmd.valid && cmd.ready;

    always_comb
    begin
        priority if (cmd_accept)
            cmd_valid_next = 1'b1;
        else if (pkt_load)
            cmd_valid_next = 1'b0;
        else
            cmd_valid_next = cmd_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else
            cmd_valid_reg <= cmd_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            cmd_reg.mode     <= cmd.mode;
            cmd_reg.servo_id <= cmd.servo_id;
            cmd_reg.value    <= cmd.value;
        end
    end

    // ------------------------------------------------------------------
    // Packet assembly and byte serialiser
    // ------------------------------------------------------------------
    scf_pkg::scf_pkt_t built_pkt;
    scf_pkg::scf_pkt_t pkt_reg;
    logic              pkt_valid_reg;
    logic              pkt_valid_next;
    logic [3:0]        idx_reg;
    logic [3:0]        idx_next;
    logic              byte_taken;
    logic              at_last;

    scf_packet_builder u_builder (
        .cmd (cmd_reg),
        .cfg (cfg_reg),
        .pkt (built_pkt)
    );

    assign at_last     = (idx_reg == pkt_reg.last_idx);
    assign byte_taken  = pkt.valid && pkt.ready;
    assign pkt_load    = cmd_valid_reg && (!pkt_valid_reg || (byte_taken && at_last));

    assign pkt.valid   = pkt_valid_reg;
    assign pkt.tx_byte = pkt_reg.bytes[idx_reg];
    assign pkt.last    = at_last;

    always_comb
    begin
        pkt_valid_next = pkt_valid_reg;
        idx_next       = idx_reg;
        priority if (pkt_load)
        begin
            pkt_valid_next = 1'b1;
            idx_next       = 4'd0;
        end
        else if (byte_taken && at_last)
        begin
            pkt_valid_next = 1'b0;
            idx_next       = 4'd0;
        end
        else if (byte_taken)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end
        else
        begin
            pkt_valid_reg <= pkt_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_load)
            pkt_reg <= built_pkt;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef NO_ASSERTIONS
    // The byte pointer never runs past the checksum of the held packet.
    a_idx_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid_reg |-> (idx_reg <= pkt_reg.last_idx))
        else $error("byte index beyond end of packet");

    // Every packet is between 6 and 11 bytes long.
    a_pkt_length: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid_reg |-> (pkt_reg.last_idx >= 4'd5 && pkt_reg.last_idx <= 4'd10))
        else $error("packet length out of range");

    // The first two bytes of each packet are the header.
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid_reg && idx_reg < 4'd2) |-> (pkt.tx_byte == scf_pkg::PKT_HEADER))
        else $error("packet header byte wrong");

    // A waiting command moves into an empty packet register straight away.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && !pkt_valid_reg) |=> (pkt_valid_reg && idx_reg == 4'd0))
        else $error("pending command not loaded");
`endif

endmodule

`default_nettype wire
